// File: hw/rtl/apu_pkg.sv
// ============================================================================
// apu_pkg - shared types and helpers for the alpha premultiply unit
// Pixel channel widths, pipeline stage payload and the divide-by-255 helper.
// ============================================================================
package apu_pkg;

  // Channel and datapath widths
  localparam int unsigned ChanW         = 8;
  localparam int unsigned NumColors     = 3;
  localparam int unsigned RemW          = 2 * ChanW;
  localparam int unsigned StepsPerStage = 2;
  // One multiply stage, then quotient bits two per stage
  localparam int unsigned NumStages     = 1 + ChanW / StepsPerStage;

  // Arithmetic constants
  localparam int unsigned MaxVal    = 255;
  localparam int unsigned RoundPrem = 127;

  typedef enum logic {
    OpPremul   = 1'b0,
    OpUnpremul = 1'b1
  } op_e;

  // Payload carried by every pipeline stage
  typedef struct packed {
    op_e                                op;
    logic [ChanW-1:0]                   alpha;
    logic                               last;
    logic [NumColors-1:0][RemW-1:0]     rem;
    logic [NumColors-1:0][ChanW-1:0]    quo;
    logic [NumColors-1:0]               sat;
  } stage_t;

  // Exact x / 255 for any 16-bit x whose quotient fits in eight bits
  function automatic logic [ChanW-1:0] div_by_255(input logic [RemW-1:0] x);
    logic [RemW:0] sum;
    sum = {1'b0, x} + (RemW+1)'(x >> ChanW) + (RemW+1)'(1);
    return sum[RemW-1:ChanW];
  endfunction

endpackage

// File: hw/rtl/alpha_premultiply_unit.sv
// ============================================================================
// alpha_premultiply_unit - BGRA premultiply / unpremultiply pipeline
// Converts one 8-bit BGRA pixel per cycle, while the output is not stalled,
// between straight and premultiplied alpha; alpha and the last-pixel mark pass through.
// ============================================================================
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  input   | valid_i / stall_o  | op_i, blue_i, green_i, red_i, alpha_i, last_i
//  output  | valid_o / stall_i  | blue_o, green_o, red_o, alpha_o, last_o
//
//  Throughput is one transaction per cycle while the output is not stalled.
//  The five register stages are one multiply stage (c*a+127 or c*255+a/2)
//  and four restoring-divide stages, each resolving two quotient bits.
//  Reset clears the stage valid bits only; the data registers are not reset.
//  A stall advances every stage that has an empty slot ahead of it, so
//  bubbles are squeezed out and no transaction is lost or repeated.
//
module alpha_premultiply_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic                      op_i,
  input  logic [apu_pkg::ChanW-1:0] blue_i,
  input  logic [apu_pkg::ChanW-1:0] green_i,
  input  logic [apu_pkg::ChanW-1:0] red_i,
  input  logic [apu_pkg::ChanW-1:0] alpha_i,
  input  logic                      last_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [apu_pkg::ChanW-1:0] blue_o,
  output logic [apu_pkg::ChanW-1:0] green_o,
  output logic [apu_pkg::ChanW-1:0] red_o,
  output logic [apu_pkg::ChanW-1:0] alpha_o,
  output logic                      last_o
);

  localparam int unsigned LastStage = apu_pkg::NumStages - 1;

  logic [apu_pkg::NumStages-1:0] vld_q;
  logic [apu_pkg::NumStages-1:0] adv;
  apu_pkg::stage_t               st_d [apu_pkg::NumStages];
  apu_pkg::stage_t               st_q [apu_pkg::NumStages];

  logic [apu_pkg::NumColors-1:0][apu_pkg::ChanW-1:0] color_in;
  logic [apu_pkg::NumColors-1:0][apu_pkg::ChanW-1:0] color_out;

  assign color_in = {red_i, green_i, blue_i};

  // Advance a stage when it is empty or the stage ahead advances
  always_comb begin
    adv[LastStage] = !vld_q[LastStage] || !stall_i;
    for (int s = LastStage - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign stall_o = !adv[0];

  // Stage 0: one multiply-add per color
  always_comb begin : stage0_comb
    logic [apu_pkg::ChanW-1:0] mul_b;
    logic [apu_pkg::ChanW-1:0] add_c;
    st_d[0].op    = apu_pkg::op_e'(op_i);
    st_d[0].alpha = alpha_i;
    st_d[0].last  = last_i;
    st_d[0].quo   = '0;
    st_d[0].sat   = '0;
    if (apu_pkg::op_e'(op_i) == apu_pkg::OpUnpremul) begin
      mul_b = apu_pkg::ChanW'(apu_pkg::MaxVal);
      add_c = {1'b0, alpha_i[apu_pkg::ChanW-1:1]};
    end else begin
      mul_b = alpha_i;
      add_c = apu_pkg::ChanW'(apu_pkg::RoundPrem);
    end
    for (int k = 0; k < apu_pkg::NumColors; k++) begin
      st_d[0].rem[k] = {{apu_pkg::ChanW{1'b0}}, color_in[k]}
                       * {{apu_pkg::ChanW{1'b0}}, mul_b}
                       + {{apu_pkg::ChanW{1'b0}}, add_c};
    end
  end

  // Stages 1..N-1: two restoring-divide steps each when unpremultiplying; stage 1 also finishes
  // premultiply and flags quotients that would pass 255
  for (genvar s = 1; s < apu_pkg::NumStages; s++) begin : g_div
    localparam int unsigned HiBit = apu_pkg::ChanW + 1 - apu_pkg::StepsPerStage * s;

    always_comb begin : div_comb
      logic [apu_pkg::RemW-1:0] dsh;
      logic [2:0]               bit_idx;
      st_d[s] = st_q[s-1];
      dsh     = '0;
      bit_idx = '0;
      if (s == 1) begin
        for (int k = 0; k < apu_pkg::NumColors; k++) begin
          if (st_q[s-1].op == apu_pkg::OpPremul) begin
            st_d[s].quo[k] = apu_pkg::div_by_255(st_q[s-1].rem[k]);
            st_d[s].sat[k] = 1'b0;
          end else begin
            st_d[s].quo[k] = '0;
            st_d[s].sat[k] = st_q[s-1].rem[k] >=
                             {st_q[s-1].alpha, {apu_pkg::ChanW{1'b0}}};
          end
        end
      end
      if (st_q[s-1].op == apu_pkg::OpUnpremul) begin
        for (int k = 0; k < apu_pkg::NumColors; k++) begin
          for (int j = 0; j < apu_pkg::StepsPerStage; j++) begin
            bit_idx = 3'(HiBit - j);
            dsh     = {{apu_pkg::ChanW{1'b0}}, st_q[s-1].alpha} << bit_idx;
            if (st_d[s].rem[k] >= dsh) begin
              st_d[s].rem[k]          = st_d[s].rem[k] - dsh;
              st_d[s].quo[k][bit_idx] = 1'b1;
            end
          end
        end
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int s = 1; s < apu_pkg::NumStages; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Stage payload, held while the stage is stalled
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < apu_pkg::NumStages; s++) begin
      if (adv[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // Select the final color: zero alpha clears, overflow saturates
  always_comb begin
    for (int k = 0; k < apu_pkg::NumColors; k++) begin
      if (st_q[LastStage].op == apu_pkg::OpUnpremul && st_q[LastStage].alpha == '0) begin
        color_out[k] = '0;
      end else if (st_q[LastStage].sat[k]) begin
        color_out[k] = apu_pkg::ChanW'(apu_pkg::MaxVal);
      end else begin
        color_out[k] = st_q[LastStage].quo[k];
      end
    end
  end

  assign valid_o = vld_q[LastStage];
  assign blue_o  = color_out[0];
  assign green_o = color_out[1];
  assign red_o   = color_out[2];
  assign alpha_o = st_q[LastStage].alpha;
  assign last_o  = st_q[LastStage].last;

  // Input stalls only when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&vld_q))
    else $error("input stalled with an empty pipeline slot");

  // An accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> vld_q[0])
    else $error("accepted transaction missing from first stage");

  // Premultiplied colors never exceed alpha
  a_premul_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && st_q[LastStage].op == apu_pkg::OpPremul) |->
      (blue_o <= alpha_o && green_o <= alpha_o && red_o <= alpha_o))
    else $error("premultiplied color above alpha");

endmodule

// File: tb/sv/tb_alpha_premultiply_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_alpha_premultiply_unit - self-checking bench for the premultiply unit
// Sends BGRA pixels with both operations through the valid/stall handshake.
// Each pixel is converted in-bench and queued. Every pixel accepted at the
// output is checked field by field against the oldest queued pixel. Random
// idle cycles fall on both sides, and a long output hold fills the pipeline.
// ============================================================================
module tb_alpha_premultiply_unit;

  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned RxHoldCycles = 300;

  typedef struct packed {
    logic [apu_pkg::ChanW-1:0] blue;
    logic [apu_pkg::ChanW-1:0] green;
    logic [apu_pkg::ChanW-1:0] red;
    logic [apu_pkg::ChanW-1:0] alpha;
    logic                      last;
  } pixel_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      valid_i;
  logic                      stall_o;
  logic                      op_i;
  logic [apu_pkg::ChanW-1:0] blue_i;
  logic [apu_pkg::ChanW-1:0] green_i;
  logic [apu_pkg::ChanW-1:0] red_i;
  logic [apu_pkg::ChanW-1:0] alpha_i;
  logic                      last_i;
  logic                      valid_o;
  logic                      stall_i;
  logic [apu_pkg::ChanW-1:0] blue_o;
  logic [apu_pkg::ChanW-1:0] green_o;
  logic [apu_pkg::ChanW-1:0] red_o;
  logic [apu_pkg::ChanW-1:0] alpha_o;
  logic                      last_o;

  pixel_t      expected_pixels[$];
  int unsigned mismatch_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        rx_hold_req;
  logic        rx_hold_on;

  alpha_premultiply_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .op_i    (op_i),
    .blue_i  (blue_i),
    .green_i (green_i),
    .red_i   (red_i),
    .alpha_i (alpha_i),
    .last_i  (last_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .blue_o  (blue_o),
    .green_o (green_o),
    .red_o   (red_o),
    .alpha_o (alpha_o),
    .last_o  (last_o)
  );

  // Generate a 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("** alpha_premultiply_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pixel conversion
  // ---------------------------------------------------------------------------

  // Scale a color by alpha with rounding
  function automatic logic [apu_pkg::ChanW-1:0] scale_by_alpha(
    logic [apu_pkg::ChanW-1:0] c, logic [apu_pkg::ChanW-1:0] a);
    int unsigned prod;
    prod = c * a + apu_pkg::RoundPrem;
    return apu_pkg::ChanW'(prod / apu_pkg::MaxVal);
  endfunction

  // Divide a color by alpha; zero alpha gives zero, overflow clamps to full scale
  function automatic logic [apu_pkg::ChanW-1:0] unscale_by_alpha(
    logic [apu_pkg::ChanW-1:0] c, logic [apu_pkg::ChanW-1:0] a);
    int unsigned quot;
    if (a == '0) begin
      return '0;
    end
    quot = (c * apu_pkg::MaxVal + (a >> 1)) / a;
    if (quot > apu_pkg::MaxVal) begin
      quot = apu_pkg::MaxVal;
    end
    return apu_pkg::ChanW'(quot);
  endfunction

  function automatic pixel_t convert_pixel(apu_pkg::op_e op, pixel_t px);
    pixel_t res;
    res = px;
    if (op == apu_pkg::OpPremul) begin
      res.blue  = scale_by_alpha(px.blue, px.alpha);
      res.green = scale_by_alpha(px.green, px.alpha);
      res.red   = scale_by_alpha(px.red, px.alpha);
    end else begin
      res.blue  = unscale_by_alpha(px.blue, px.alpha);
      res.green = unscale_by_alpha(px.green, px.alpha);
      res.red   = unscale_by_alpha(px.red, px.alpha);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random pixels
  // ---------------------------------------------------------------------------

  // Mostly valid premultiplied data for unpremultiply, with some colors above alpha
  function automatic logic [apu_pkg::ChanW-1:0] random_color(
    apu_pkg::op_e op, logic [apu_pkg::ChanW-1:0] a);
    if (op == apu_pkg::OpUnpremul && $urandom_range(3) != 0) begin
      return apu_pkg::ChanW'($urandom_range(a));
    end
    return apu_pkg::ChanW'($urandom_range(apu_pkg::MaxVal));
  endfunction

  function automatic pixel_t random_pixel(apu_pkg::op_e op);
    pixel_t px;
    case ($urandom_range(7))
      0:       px.alpha = '0;
      1:       px.alpha = '1;
      default: px.alpha = apu_pkg::ChanW'($urandom_range(apu_pkg::MaxVal));
    endcase
    px.blue  = random_color(op, px.alpha);
    px.green = random_color(op, px.alpha);
    px.red   = random_color(op, px.alpha);
    px.last  = ($urandom_range(15) == 0);
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endtask

  // Offer one pixel, hold it until accepted, then queue its expected result
  task automatic send_pixel(apu_pkg::op_e op, pixel_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    op_i    <= op;
    blue_i  <= px.blue;
    green_i <= px.green;
    red_i   <= px.red;
    alpha_i <= px.alpha;
    last_i  <= px.last;
    do @(posedge clk_i); while (stall_o);
    expected_pixels.push_back(convert_pixel(op, px));
  endtask

  // Stop offering and wait for every queued result
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    valid_i <= 1'b0;
    while (expected_pixels.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
      expected_pixels.delete();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Long output hold: count the stretch once a test requests it
  // ---------------------------------------------------------------------------
  initial begin
    rx_hold_on <= 1'b0;
    forever begin
      wait (rx_hold_req === 1'b1);
      rx_hold_on <= 1'b1;
      repeat (RxHoldCycles) @(posedge clk_i);
      rx_hold_on <= 1'b0;
      wait (rx_hold_req !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: drive stall and check each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result b=%0d g=%0d r=%0d a=%0d",
                                  blue_o, green_o, red_o, alpha_o));
      end else begin
        want = expected_pixels.pop_front();
        if (blue_o !== want.blue)
          report_mismatch($sformatf("blue got %0d want %0d", blue_o, want.blue));
        if (green_o !== want.green)
          report_mismatch($sformatf("green got %0d want %0d", green_o, want.green));
        if (red_o !== want.red)
          report_mismatch($sformatf("red got %0d want %0d", red_o, want.red));
        if (alpha_o !== want.alpha)
          report_mismatch($sformatf("alpha got %0d want %0d", alpha_o, want.alpha));
        if (last_o !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", last_o, want.last));
      end
    end
    // Hold while the long stretch runs, else stall at random
    if (rx_hold_on) begin
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Premultiply: full and zero alpha, full and zero colors, rounding points
  task automatic test_premultiply_corners();
    send_pixel(apu_pkg::OpPremul, '{blue: 0,   green: 0,   red: 0,   alpha: 0,   last: 0});
    send_pixel(apu_pkg::OpPremul, '{blue: 255, green: 255, red: 255, alpha: 0,   last: 1});
    send_pixel(apu_pkg::OpPremul, '{blue: 255, green: 255, red: 255, alpha: 255, last: 0});
    send_pixel(apu_pkg::OpPremul, '{blue: 0,   green: 128, red: 255, alpha: 128, last: 1});
    send_pixel(apu_pkg::OpPremul, '{blue: 1,   green: 2,   red: 254, alpha: 1,   last: 0});
    send_pixel(apu_pkg::OpPremul, '{blue: 255, green: 0,   red: 127, alpha: 254, last: 1});
    wait_drained();
  endtask

  // Unpremultiply: opaque, color equal to alpha, rounding
  task automatic test_unpremultiply_corners();
    send_pixel(apu_pkg::OpUnpremul, '{blue: 0,   green: 128, red: 255, alpha: 255, last: 0});
    send_pixel(apu_pkg::OpUnpremul, '{blue: 100, green: 100, red: 100, alpha: 100, last: 1});
    send_pixel(apu_pkg::OpUnpremul, '{blue: 1,   green: 1,   red: 1,   alpha: 2,   last: 0});
    send_pixel(apu_pkg::OpUnpremul, '{blue: 127, green: 128, red: 129, alpha: 128, last: 1});
    wait_drained();
  endtask

  // Unpremultiply with zero alpha clears every color
  task automatic test_zero_alpha();
    send_pixel(apu_pkg::OpUnpremul, '{blue: 255, green: 128, red: 0,   alpha: 0, last: 0});
    send_pixel(apu_pkg::OpUnpremul, '{blue: 0,   green: 0,   red: 0,   alpha: 0, last: 1});
    send_pixel(apu_pkg::OpUnpremul, '{blue: 255, green: 255, red: 255, alpha: 0, last: 0});
    wait_drained();
  endtask

  // Unpremultiply with some colors above alpha, which clamp to full scale
  task automatic test_saturation();
    send_pixel(apu_pkg::OpUnpremul, '{blue: 1,   green: 0,   red: 255, alpha: 1,   last: 1});
    send_pixel(apu_pkg::OpUnpremul, '{blue: 200, green: 255, red: 60,  alpha: 50,  last: 0});
    send_pixel(apu_pkg::OpUnpremul, '{blue: 255, green: 254, red: 253, alpha: 254, last: 1});
    wait_drained();
  endtask

  // Random pixels and operations under the given idle rates
  task automatic test_random_stream(int unsigned count, int unsigned tx_pct,
                                    int unsigned rx_pct);
    apu_pkg::op_e op;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      op = apu_pkg::op_e'($urandom_range(1));
      send_pixel(op, random_pixel(op));
    end
    wait_drained();
  endtask

  // Hold the output for a long stretch while pixels keep arriving
  task automatic test_backpressure();
    apu_pkg::op_e op;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    repeat (40) begin
      op = apu_pkg::op_e'($urandom_range(1));
      send_pixel(op, random_pixel(op));
    end
    wait_drained();
    rx_hold_req = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_req    = 1'b0;
    rst_ni  <= 1'b0;
    valid_i <= 1'b0;
    stall_i <= 1'b0;
    op_i    <= apu_pkg::OpPremul;
    blue_i  <= '0;
    green_i <= '0;
    red_i   <= '0;
    alpha_i <= '0;
    last_i  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_premultiply_corners();
    test_unpremultiply_corners();
    test_zero_alpha();
    test_saturation();
    test_random_stream(420, 17, 71);
    test_random_stream(420, 71, 17);
    test_backpressure();
    test_random_stream(410, 0, 0);

    // Let any stray result show up
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** alpha_premultiply_unit: PASSED **");
    end else begin
      $display("** alpha_premultiply_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/apu_pkg.sv
hw/rtl/alpha_premultiply_unit.sv
tb/sv/tb_alpha_premultiply_unit.sv
